// ===== sv/spq_pkg.sv =====
`timescale 1ns / 1ps
package spq_pkg;

	localparam logic [1:0] CMD_ENQ = 2'd0;
	localparam logic [1:0] CMD_DEQ = 2'd1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DROP   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_PURGED = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [2:0]  prio;
		logic [15:0] pkt_handle;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] out_handle;
		logic [2:0]  out_prio;
		logic [8:0]  queued_count;
		logic [31:0] drop_count;
		logic [8:0]  purged_count;
	} rsp_t;

endpackage

// ===== sv/spq_ram.sv =====
`timescale 1ns / 1ps
module spq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/strict_priority_packet_queue.sv =====
`timescale 1ns / 1ps
// enqueue, dequeue and purge: the result is valid after states S_RD and S_WR
//   (S_RD reads the link and handle memories and writes back, S_WR loads the result register)
// one request at a time: a new request waits in S_IDLE until the result has gone
// purge: all slots freed at once by resetting the free-slot allocator
// reset: asynchronous, empties every fifo, drop count zero, max_len 256; no clearing pass
module strict_priority_packet_queue
	import spq_pkg::*;
#(
	parameter int NUM_PRIO    = 8,
	parameter int CAPACITY    = 256,
	parameter int HANDLE_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  req_t       in_data,
	output logic       out_valid,
	input  logic       out_ready,
	output rsp_t       out_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [8:0] cfg_data
);
	localparam int SW = $clog2(CAPACITY);
	localparam int PW = $clog2(NUM_PRIO);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {S_IDLE, S_RD, S_WR} state_t;

	state_t                 state_q;
	logic [8:0]             max_len_q;
	logic [NUM_PRIO-1:0]    mask_q;
	logic [CW-1:0]          total_q;
	logic [31:0]            drops_q;
	logic [SW-1:0]          head_q [NUM_PRIO];
	logic [SW-1:0]          tail_q [NUM_PRIO];
	req_t                   req_q;
	logic [PW-1:0]          p_q;
	logic                   rsp_full_q;
	rsp_t                   rsp_q;
	// free slots: fresh slots counted by fill_q, recycled ones on a stack
	logic [CW-1:0]          fill_q;
	logic [CW-1:0]          fsp_q;

	logic                   st_we, lk_we, fr_we;
	logic [SW-1:0]          st_wa, lk_wa, fr_wa, st_ra, lk_ra, fr_ra;
	logic [HANDLE_BITS-1:0] st_wd, st_rd;
	logic [SW-1:0]          lk_wd, lk_rd, fr_wd, fr_rd;

	spq_ram #(.WIDTH(HANDLE_BITS), .DEPTH(CAPACITY)) u_store (
		.clk, .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(st_ra), .rdata(st_rd));
	spq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link (
		.clk, .we(lk_we), .waddr(lk_wa), .wdata(lk_wd), .raddr(lk_ra), .rdata(lk_rd));
	spq_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_free (
		.clk, .we(fr_we), .waddr(fr_wa), .wdata(fr_wd), .raddr(fr_ra), .rdata(fr_rd));

	logic              take;
	logic [PW-1:0]     ep, top;
	logic              any;
	logic              full;
	logic [SW-1:0]     hs;
	logic [SW-1:0]     eslot;

	assign in_ready  = (state_q == S_IDLE) && !rsp_full_q;
	assign cfg_ready = 1'b1;
	assign take      = in_valid && in_ready;
	assign out_valid = rsp_full_q;
	assign out_data  = rsp_q;

	always_comb begin
		ep = (32'(in_data.prio) >= NUM_PRIO) ? PW'(NUM_PRIO - 1) : PW'(in_data.prio);
		top = '0;
		any = |mask_q;
		for (int i = 0; i < NUM_PRIO; i++) begin
			if (mask_q[i]) begin
				top = PW'(i);
			end
		end
		full = (32'(total_q) >= 32'(max_len_q)) || (32'(total_q) >= CAPACITY);
		hs = head_q[p_q];
		eslot = (fsp_q != '0) ? fr_rd : fill_q[SW-1:0];
	end

	// read addresses are issued on acceptance, data used in S_RD
	always_comb begin
		st_ra = hs;
		lk_ra = hs;
		fr_ra = SW'(fsp_q - CW'(1));
		st_we = 1'b0; st_wa = eslot; st_wd = req_q.pkt_handle[HANDLE_BITS-1:0];
		lk_we = 1'b0; lk_wa = tail_q[p_q]; lk_wd = eslot;
		fr_we = 1'b0; fr_wa = fsp_q[SW-1:0]; fr_wd = hs;
		if (state_q == S_IDLE) begin
			st_ra = head_q[top];
			lk_ra = head_q[top];
		end
		if (state_q == S_RD && req_q.cmd == CMD_ENQ && !full) begin
			st_we = 1'b1;
			lk_we = mask_q[p_q];
		end
		if (state_q == S_RD && req_q.cmd == CMD_DEQ && any && total_q != '0) begin
			fr_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			max_len_q  <= 9'd256;
			mask_q     <= '0;
			total_q    <= '0;
			drops_q    <= '0;
			rsp_full_q <= 1'b0;
			fill_q     <= '0;
			fsp_q      <= '0;
		end else begin
			if (cfg_valid) begin
				max_len_q <= cfg_data;
			end
			if (out_valid && out_ready) begin
				rsp_full_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						req_q   <= in_data;
						p_q     <= (in_data.cmd == CMD_ENQ) ? ep : top;
						state_q <= S_RD;
					end
				end
				S_RD: begin
					state_q <= S_WR;
					rsp_q.status       <= ST_OK;
					rsp_q.out_handle   <= '0;
					rsp_q.out_prio     <= '0;
					rsp_q.purged_count <= '0;
					if (req_q.cmd == CMD_ENQ) begin
						if (full) begin
							rsp_q.status <= ST_DROP;
							drops_q <= drops_q + 32'd1;
						end else begin
							if (!mask_q[p_q]) begin
								head_q[p_q] <= eslot;
							end
							tail_q[p_q] <= eslot;
							mask_q[p_q] <= 1'b1;
							total_q <= total_q + CW'(1);
							if (fsp_q != '0) begin
								fsp_q <= fsp_q - CW'(1);
							end else begin
								fill_q <= fill_q + CW'(1);
							end
						end
					end else if (req_q.cmd == CMD_DEQ) begin
						if (!any) begin
							rsp_q.status <= ST_EMPTY;
						end else begin
							rsp_q.out_handle <= 16'(st_rd);
							rsp_q.out_prio   <= 3'(p_q);
							if (hs == tail_q[p_q]) begin
								mask_q[p_q] <= 1'b0;
							end else begin
								head_q[p_q] <= lk_rd;
							end
							if (total_q != '0) begin
								fsp_q   <= fsp_q + CW'(1);
								total_q <= total_q - CW'(1);
							end
						end
					end else begin
						rsp_q.status       <= ST_PURGED;
						rsp_q.purged_count <= 9'(total_q);
						drops_q <= drops_q + 32'(total_q);
						total_q <= '0;
						mask_q  <= '0;
						fill_q  <= '0;
						fsp_q   <= '0;
					end
				end
				S_WR: begin
					rsp_q.queued_count <= 9'(total_q);
					rsp_q.drop_count   <= drops_q;
					rsp_full_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/spq_checker.sv =====
`timescale 1ns / 1ps
module spq_checker
	import spq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input rsp_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped or changed while stalled");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken twice");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid)
		else $error("request taken with result pending");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.queued_count <= 9'd256)
		else $error("queued count out of range");
endmodule

bind strict_priority_packet_queue spq_checker u_spq_checker (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data);
